// ===== src/aet_pkg.sv =====
// Shared types and constants for the arithmetic expression tokenizer.
// No dependencies; imported by every other module of the block.

package aet_pkg;

  localparam int AET_INT_BITS    = 32;
  localparam int AET_FRAC_DIGITS = 9;
  localparam int AET_QUEUE_DEPTH = 4;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // powers of ten, enough for one digit past the largest fraction length
  localparam logic [63:0] POW10 [0:17] = '{
    64'd1, 64'd10, 64'd100, 64'd1000, 64'd10000, 64'd100000, 64'd1000000,
    64'd10000000, 64'd100000000, 64'd1000000000, 64'd10000000000,
    64'd100000000000, 64'd1000000000000, 64'd10000000000000,
    64'd100000000000000, 64'd1000000000000000, 64'd10000000000000000,
    64'd100000000000000000
  };

  typedef enum logic [3:0] {
    TK_PLUS   = 4'd0,
    TK_MINUS  = 4'd1,
    TK_TIMES  = 4'd2,
    TK_DIVIDE = 4'd3,
    TK_LPAREN = 4'd4,
    TK_RPAREN = 4'd5,
    TK_NUMBER = 4'd6,
    TK_ERROR  = 4'd7,
    TK_END    = 4'd8
  } token_kind_e;

  typedef enum logic [2:0] {
    LM_IDLE     = 3'd0,
    LM_INT      = 3'd1,
    LM_DOT      = 3'd2,
    LM_FRAC     = 3'd3,
    LM_ERR_INT  = 3'd4,
    LM_ERR_FRAC = 3'd5
  } lex_mode_e;

  typedef struct packed {
    token_kind_e kind;
    logic [63:0] value;
    logic        last;
  } token_t;

  typedef struct packed {
    logic [1:0] count;
    token_t     tok_a;
    token_t     tok_b;
  } lex_out_t;

endpackage

// ===== src/arith_expr_tokenizer.sv =====
// Top level of the arithmetic expression tokenizer: lexer plus token queue.
// Depends on aet_pkg, aet_lexer and aet_tok_queue.
//
// One character is taken per clock while in_ready_o is high; its tokens are
// queued before they reach the output. Numbers come out as unsigned Q32.32
// when the character that ends them arrives, and that character's own token
// follows as a second transaction. A four-token queue sits between lexer and
// output; in_ready_o is high while it has room for two tokens, so with the
// output always taken the block sustains one character per cycle, and falls
// to the output's pace only while tokens pile up.

module arith_expr_tokenizer import aet_pkg::*; #(
  parameter int INT_BITS    = AET_INT_BITS,
  parameter int FRAC_DIGITS = AET_FRAC_DIGITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  token_kind_o,
  output logic [63:0] number_value_o,
  output logic        last_of_run_o
);

  lex_out_t lex_out;
  token_t   head_tok;
  logic     step;
  logic     space;

  assign in_ready_o = space;
  assign step       = in_valid_i && space;

  aet_lexer #(
    .INT_BITS    (INT_BITS),
    .FRAC_DIGITS (FRAC_DIGITS)
  ) u_lexer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .char_i (char_in_i),
    .lex_o  (lex_out)
  );

  aet_tok_queue #(
    .DEPTH (AET_QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (step),
    .push_data_i (lex_out),
    .space_o     (space),
    .valid_o     (out_valid_o),
    .pop_i       (out_ready_i),
    .tok_o       (head_tok)
  );

  assign token_kind_o   = head_tok.kind;
  assign number_value_o = head_tok.value;
  assign last_of_run_o  = head_tok.last;

endmodule

// ===== src/aet_lexer.sv =====
// Lexer state and per-character next-state logic; fraction kept as running
// binary quotient and decimal remainder. Depends on aet_pkg.

module aet_lexer import aet_pkg::*; #(
  parameter int INT_BITS    = AET_INT_BITS,
  parameter int FRAC_DIGITS = AET_FRAC_DIGITS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] char_i,
  output lex_out_t   lex_o
);

  localparam int IW  = (INT_BITS >= 32) ? 32 : INT_BITS;
  localparam int IXW = IW + 4;
  localparam int RW  = $clog2(POW10[FRAC_DIGITS]);
  localparam int RW1 = RW + 1;
  localparam int RT  = RW + 4;
  localparam int CW  = $clog2(FRAC_DIGITS + 1);

  lex_mode_e       mode_q, mode_d;
  logic [IW-1:0]   int_q, int_d;
  logic [31:0]     quo_q, quo_d;
  logic [RW-1:0]   rem_q, rem_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            fz_q, fz_d;

  // per length: 10^n for rounding, 10^(n+1) and digit * 2^32 / 10^(n+1)
  logic [RW1-1:0]  pn_tab [FRAC_DIGITS+1];
  logic [RT-1:0]   pk_tab [FRAC_DIGITS+1];
  logic [31:0]     dq_tab [FRAC_DIGITS+1][10];
  logic [RW-1:0]   dr_tab [FRAC_DIGITS+1][10];

  for (genvar k = 0; k <= FRAC_DIGITS; k++) begin : g_len
    localparam logic [63:0] PN = POW10[k];
    localparam logic [63:0] PK = POW10[k+1];
    assign pn_tab[k] = PN[RW1-1:0];
    assign pk_tab[k] = PK[RT-1:0];
    for (genvar dd = 0; dd < 10; dd++) begin : g_dig
      localparam logic [63:0] NUM = 64'(dd) << 32;
      localparam logic [63:0] DQ  = NUM / PK;
      localparam logic [63:0] DR  = NUM % PK;
      assign dq_tab[k][dd] = DQ[31:0];
      assign dr_tab[k][dd] = DR[RW-1:0];
    end
  end

  logic            is_digit;
  logic [3:0]      dig;
  logic [IXW-1:0]  int_ext;
  logic [RT-1:0]   frac_t;
  logic [RT-1:0]   frac_diff;
  logic            frac_ge;
  logic            rnd_up;
  logic [32:0]     fr_sum;
  logic [31:0]     ip_val;
  logic [31:0]     fr_val;
  logic [63:0]     num_val;

  assign is_digit = char_i inside {[CH_ZERO:CH_NINE]};
  assign dig      = is_digit ? 4'(char_i - CH_ZERO) : 4'd0;

  assign int_ext = IXW'({int_q, 3'b000}) + IXW'({int_q, 1'b0}) + IXW'(dig);

  assign frac_t    = RT'({rem_q, 3'b000}) + RT'({rem_q, 1'b0}) + RT'(dr_tab[cnt_q][dig]);
  assign frac_diff = frac_t - pk_tab[cnt_q];
  assign frac_ge   = frac_t >= pk_tab[cnt_q];

  // conversion of the held number, halves round up
  assign rnd_up = {rem_q, 1'b0} >= pn_tab[cnt_q];
  assign fr_sum = {1'b0, quo_q} + 33'(rnd_up);

  always_comb begin
    ip_val = 32'(int_q);
    fr_val = fr_sum[31:0];
    if (fr_sum[32]) begin
      if (&int_q) begin
        fr_val = '1;
      end else begin
        ip_val = 32'(int_q) + 32'd1;
        fr_val = '0;
      end
    end
  end

  assign num_val = {ip_val, fr_val};

  token_kind_e  kind_a, kind_b;
  logic [63:0]  val_a;
  logic         emit_a, emit_b;
  logic         lex_idle;

  always_comb begin
    mode_d   = mode_q;
    int_d    = int_q;
    quo_d    = quo_q;
    rem_d    = rem_q;
    cnt_d    = cnt_q;
    fz_d     = fz_q;
    emit_a   = 1'b0;
    emit_b   = 1'b0;
    kind_a   = TK_ERROR;
    kind_b   = TK_ERROR;
    val_a    = '0;
    lex_idle = (mode_q == LM_IDLE);

    if (mode_q != LM_IDLE) begin
      if (is_digit) begin
        case (mode_q)
          LM_INT: begin
            if (fz_q) begin
              mode_d = LM_ERR_INT;
            end else if (|int_ext[IXW-1:IW]) begin
              int_d = '1;
            end else begin
              int_d = int_ext[IW-1:0];
            end
          end
          LM_DOT, LM_FRAC: begin
            mode_d = LM_FRAC;
            if (cnt_q < CW'(FRAC_DIGITS)) begin
              quo_d = quo_q + dq_tab[cnt_q][dig] + 32'(frac_ge);
              rem_d = frac_ge ? frac_diff[RW-1:0] : frac_t[RW-1:0];
              cnt_d = cnt_q + CW'(1);
            end
          end
          default: ;
        endcase
      end else if (char_i == CH_DOT && mode_q == LM_INT) begin
        mode_d = LM_DOT;
      end else if (char_i == CH_DOT && mode_q == LM_ERR_INT) begin
        mode_d = LM_ERR_FRAC;
      end else begin
        emit_a = 1'b1;
        if (mode_q == LM_INT || mode_q == LM_FRAC) begin
          kind_a = TK_NUMBER;
          val_a  = num_val;
        end
        mode_d   = LM_IDLE;
        int_d    = '0;
        quo_d    = '0;
        rem_d    = '0;
        cnt_d    = '0;
        fz_d     = 1'b0;
        lex_idle = 1'b1;
      end
    end

    if (lex_idle) begin
      if (is_digit) begin
        int_d  = IW'(dig);
        quo_d  = '0;
        rem_d  = '0;
        cnt_d  = '0;
        fz_d   = (dig == 4'd0);
        mode_d = LM_INT;
      end else begin
        emit_b = 1'b1;
        case (char_i)
          CH_SPACE, CH_TAB: emit_b = 1'b0;
          CH_PLUS:  kind_b = TK_PLUS;
          CH_MINUS: kind_b = TK_MINUS;
          CH_STAR:  kind_b = TK_TIMES;
          CH_SLASH: kind_b = TK_DIVIDE;
          CH_LPAR:  kind_b = TK_LPAREN;
          CH_RPAR:  kind_b = TK_RPAREN;
          CH_NUL: begin
            kind_b = TK_END;
            int_d  = '0;
            quo_d  = '0;
            rem_d  = '0;
            cnt_d  = '0;
            fz_d   = 1'b0;
          end
          default:  kind_b = TK_ERROR;
        endcase
      end
    end
  end

  always_comb begin
    lex_o.tok_a = '{kind: kind_a, value: val_a, last: ~emit_b};
    lex_o.tok_b = '{kind: kind_b, value: 64'd0, last: 1'b1};
    lex_o.count = 2'd0;
    if (emit_a && emit_b) begin
      lex_o.count = 2'd2;
    end else if (emit_a) begin
      lex_o.count = 2'd1;
    end else if (emit_b) begin
      lex_o.count = 2'd1;
      lex_o.tok_a = lex_o.tok_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= LM_IDLE;
      int_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      cnt_q  <= '0;
      fz_q   <= 1'b0;
    end else if (step_i) begin
      mode_q <= mode_d;
      int_q  <= int_d;
      quo_q  <= quo_d;
      rem_q  <= rem_d;
      cnt_q  <= cnt_d;
      fz_q   <= fz_d;
    end
  end

endmodule

// ===== src/aet_tok_queue.sv =====
// Small token queue between lexer and output port; takes up to two tokens
// per cycle, gives one. Depends on aet_pkg.

module aet_tok_queue import aet_pkg::*; #(
  parameter int DEPTH = AET_QUEUE_DEPTH
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  lex_out_t push_data_i,
  output logic     space_o,
  output logic     valid_o,
  input  logic     pop_i,
  output token_t   tok_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  token_t          mem [DEPTH];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [NW-1:0]   count_q, count_d;
  logic [1:0]      push_n;
  logic            pop;

  assign push_n  = push_i ? push_data_i.count : 2'd0;
  assign valid_o = (count_q != '0);
  assign pop     = pop_i && valid_o;
  assign space_o = (count_q <= NW'(DEPTH - 2));
  assign tok_o   = mem[rd_ptr_q];

  assign wr_ptr_d = wr_ptr_q + PW'(push_n);
  assign rd_ptr_d = rd_ptr_q + PW'(pop);
  assign count_d  = count_q + NW'(push_n) - NW'(pop);

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      mem[wr_ptr_q] <= push_data_i.tok_a;
    end
    if (push_n == 2'd2) begin
      mem[wr_ptr_q + PW'(1)] <= push_data_i.tok_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== dv/token_checker.sv =====
`timescale 1ns / 100ps
// Token checker for the arithmetic expression tokenizer: predicts the tokens of
// each accepted character and compares output transactions with them in order.
// Depends on aet_pkg only.

module token_checker import aet_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  char_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [3:0]  kind_i,
  input  logic [63:0] value_i,
  input  logic        last_i,
  output int          err_count_o,
  output int          pending_o
);

  lex_mode_e   lex_state;
  logic [63:0] int_acc;
  logic [63:0] frac_acc;
  int          frac_cnt;
  logic        lead_zero;
  token_t      expected_tokens [$];
  token_t      want;
  int          errors;
  int          n_new;

  function automatic logic [63:0] int_top();
    if (AET_INT_BITS >= 32) return 64'hFFFF_FFFF;
    return (64'd1 << AET_INT_BITS) - 64'd1;
  endfunction

  // integer part in the top half, fraction F / 10^n rounded half up in the bottom
  function automatic logic [63:0] q32_32(input logic [63:0] ip, input logic [63:0] f,
                                         input int n);
    logic [63:0] p;
    logic [63:0] r;
    logic [63:0] fr;
    p  = 64'd1;
    r  = f;
    fr = 64'd0;
    for (int i = 0; i < n && i < 15; i++) p = p * 64'd10;
    if (r >= p) r = p - 64'd1;
    for (int i = 0; i < 32; i++) begin
      r  = r << 1;
      fr = fr << 1;
      if (r >= p) begin
        r  = r - p;
        fr = fr | 64'd1;
      end
    end
    if (r * 2 >= p) fr = fr + 64'd1;
    if (fr > 64'hFFFF_FFFF) begin
      if (ip >= int_top()) begin
        fr = 64'hFFFF_FFFF;
      end else begin
        ip = ip + 64'd1;
        fr = 64'd0;
      end
    end
    return {ip[31:0], fr[31:0]};
  endfunction

  task automatic push_token(input token_kind_e kind, input logic [63:0] value);
    token_t t;
    t.kind  = kind;
    t.value = value;
    t.last  = 1'b0;
    expected_tokens.push_back(t);
    n_new++;
  endtask

  task automatic clear_number();
    int_acc   = '0;
    frac_acc  = '0;
    frac_cnt  = 0;
    lead_zero = 1'b0;
  endtask

  task automatic lex_char(input logic [7:0] c);
    logic        digit;
    logic [63:0] d;
    logic        taken;
    digit = (c >= CH_ZERO) && (c <= CH_NINE);
    d     = 64'(c - CH_ZERO);
    taken = 1'b0;
    n_new = 0;
    if (lex_state != LM_IDLE) begin
      if (digit) begin
        taken = 1'b1;
        case (lex_state)
          LM_INT: begin
            if (lead_zero) begin
              lex_state = LM_ERR_INT;
            end else begin
              int_acc = int_acc * 64'd10 + d;
              if (int_acc > int_top()) int_acc = int_top();
            end
          end
          LM_DOT, LM_FRAC: begin
            lex_state = LM_FRAC;
            if (frac_cnt < AET_FRAC_DIGITS) begin
              frac_acc = frac_acc * 64'd10 + d;
              frac_cnt++;
            end
          end
          default: ;
        endcase
      end else if (c == CH_DOT && lex_state == LM_INT) begin
        lex_state = LM_DOT;
        taken     = 1'b1;
      end else if (c == CH_DOT && lex_state == LM_ERR_INT) begin
        lex_state = LM_ERR_FRAC;
        taken     = 1'b1;
      end else begin
        if (lex_state == LM_INT || lex_state == LM_FRAC)
          push_token(TK_NUMBER, q32_32(int_acc, frac_acc, frac_cnt));
        else
          push_token(TK_ERROR, '0);
        lex_state = LM_IDLE;
        clear_number();
      end
    end
    // the character that ended a lexeme is lexed afresh
    if (!taken) begin
      if (digit) begin
        clear_number();
        int_acc   = d;
        lead_zero = (d == 64'd0);
        lex_state = LM_INT;
      end else begin
        case (c)
          CH_SPACE, CH_TAB: ;
          CH_PLUS:  push_token(TK_PLUS, '0);
          CH_MINUS: push_token(TK_MINUS, '0);
          CH_STAR:  push_token(TK_TIMES, '0);
          CH_SLASH: push_token(TK_DIVIDE, '0);
          CH_LPAR:  push_token(TK_LPAREN, '0);
          CH_RPAR:  push_token(TK_RPAREN, '0);
          CH_NUL: begin
            push_token(TK_END, '0);
            clear_number();
          end
          default:  push_token(TK_ERROR, '0);
        endcase
      end
    end
    if (n_new > 0) expected_tokens[expected_tokens.size() - 1].last = 1'b1;
  endtask

  task automatic report(input string msg);
    if (errors < 100) $display("[%0t] %s", $time, msg);
    errors++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lex_state = LM_IDLE;
      clear_number();
      expected_tokens.delete();
      errors = 0;
      err_count_o <= 0;
      pending_o   <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_tokens.size() == 0) begin
          report($sformatf("unexpected token: kind %0d value %h last %b",
                           kind_i, value_i, last_i));
        end else begin
          want = expected_tokens.pop_front();
          if (kind_i !== want.kind || value_i !== want.value || last_i !== want.last)
            report($sformatf("token mismatch: got kind %0d value %h last %b, want %0d %h %b",
                             kind_i, value_i, last_i, want.kind, want.value, want.last));
        end
      end
      if (in_valid_i && in_ready_i) lex_char(char_i);
      err_count_o <= errors;
      pending_o   <= expected_tokens.size();
    end
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// Top of the tokenizer testbench: clock, reset, character stimulus and output
// back-pressure. Depends on aet_pkg, arith_expr_tokenizer and token_checker.

module testbench import aet_pkg::*; ();

  localparam logic [7:0] OP_CHARS [6] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH,
                                          CH_LPAR, CH_RPAR};

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic [7:0]  char_in   = 8'h00;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [3:0]  kind;
  logic [63:0] value;
  logic        last;
  int          err_count;
  int          pending;
  int          sent      = 0;
  int          stall     = 0;
  int          ready_wait;
  bit          no_idle   = 1'b0;
  int          pick;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  arith_expr_tokenizer u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .char_in_i      (char_in),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .token_kind_o   (kind),
    .number_value_o (value),
    .last_of_run_o  (last)
  );

  token_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .char_i      (char_in),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .kind_i      (kind),
    .value_i     (value),
    .last_i      (last),
    .err_count_o (err_count),
    .pending_o   (pending)
  );

  // after each output transaction ready may drop for a random stall, unless no_idle is set
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall     <= 0;
    end else if (out_ready) begin
      if (out_valid) begin
        ready_wait = no_idle ? 0 : $urandom_range(0, 3);
        if (ready_wait != 0) begin
          out_ready <= 1'b0;
          stall     <= ready_wait;
        end
      end
    end else begin
      if (stall <= 1) out_ready <= 1'b1;
      stall <= stall - 1;
    end
  end

  task automatic send_char(input logic [7:0] c);
    int gap;
    if ($urandom_range(0, 99) == 0) no_idle = !no_idle;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    char_in  <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (c != CH_SPACE && c != CH_TAB) sent++;
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send_char(s[i]);
  endtask

  task automatic send_digits(input int count, input bit nines);
    for (int i = 0; i < count; i++)
      send_char(nines ? CH_NINE : CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  // mostly well-formed numbers; some with leading zero, bare dot or overlong parts
  task automatic send_number();
    int shape;
    if ($urandom_range(0, 9) == 0) send_char(CH_ZERO);
    else send_char(CH_ZERO + 8'($urandom_range(1, 9)));
    if ($urandom_range(0, 7) == 0)
      send_digits($urandom_range(9, 11), 1'($urandom_range(0, 1)));
    else send_digits($urandom_range(0, 3), 1'b0);
    if ($urandom_range(0, 1) == 1) begin
      send_char(CH_DOT);
      shape = $urandom_range(0, 9);
      if (shape == 0) ;
      else if (shape == 1) send_digits($urandom_range(8, 12), 1'($urandom_range(0, 1)));
      else send_digits($urandom_range(1, 4), 1'b0);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send_text("(+-*/)\t 0.5 01.2.3 1.x.");
    send_char(8'hFF);
    send_char(CH_NUL);
    send_text("99999999999.1234567891234");
    send_char(CH_NUL);

    while (sent < 2000) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) send_number();
      else if (pick < 70) send_char(OP_CHARS[3'($urandom_range(0, 5))]);
      else if (pick < 80) send_char($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
      else if (pick < 87) send_char(CH_NUL);
      else if (pick < 94) send_char(8'($urandom_range(0, 255)));
      else send_char(CH_DOT);
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== files.f =====
src/aet_pkg.sv
src/aet_lexer.sv
src/aet_tok_queue.sv
src/arith_expr_tokenizer.sv
dv/token_checker.sv
dv/testbench.sv
